// ===== src/sdf_pkg.sv =====
package sdf_pkg;

    localparam int WINDOW_DEPTH_DEF  = 100;
    localparam int ADAPTER_COUNT_DEF = 8;

    localparam int SEQ_W    = 32;
    localparam int ADAPT_W  = 3;
    localparam int SIG_W    = 8;
    localparam int LEN_W    = 9;
    localparam int SLOT_W   = 7;
    localparam int PKT_W    = 32;

    localparam logic signed [SIG_W-1:0] SIGNAL_RESET = -8'sd126;

    typedef enum logic [1:0] {
        V_ACCEPT = 2'd0,
        V_DUP    = 2'd1,
        V_OLD    = 2'd2
    } t_verdict;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [SEQ_W-1:0]          sequence_req;
        logic [ADAPT_W-1:0]        adapter;
        logic signed [SIG_W-1:0]   signal_dbm;
        logic [LEN_W-1:0]          payload_length;
    } t_in;

    typedef struct packed {
        t_verdict                  verdict;
        logic [SLOT_W-1:0]         slot;
        logic [LEN_W-1:0]          forward_length;
        logic [PKT_W-1:0]          adapter_packets;
    } t_out;

    // top -> window
    typedef struct packed {
        logic start;
        logic commit;
    } t_win_ctl;

    // window -> top
    typedef struct packed {
        logic done;
        logic dup;
    } t_win_sts;

endpackage

// ===== src/sdf_window.sv =====
module sdf_window #(
    parameter int DEPTH = sdf_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sdf_pkg::t_win_ctl         i_ctl,
    input  logic [sdf_pkg::SEQ_W-1:0] i_key,
    output sdf_pkg::t_win_sts         o_sts,
    output logic [$clog2(DEPTH)-1:0]  o_ptr
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [sdf_pkg::SEQ_W-1:0] r_mem [DEPTH];
    logic [sdf_pkg::SEQ_W-1:0] r_q;
    logic [sdf_pkg::SEQ_W-1:0] r_key;
    logic [PW-1:0]             r_ptr;
    logic [CW-1:0]             r_fill;
    logic [CW-1:0]             r_iss;
    logic [PW-1:0]             r_addr;
    logic                      r_busy;
    logic                      r_cmp_en;
    logic                      r_cmp_live;
    logic                      r_dup;
    logic                      r_done;

    logic [sdf_pkg::SEQ_W-1:0] cmp_val;
    logic                      match;
    logic                      issue;
    logic                      last;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] a);
        wrap_inc = (a == PW'(DEPTH - 1)) ? '0 : a + 1'b1;
    endfunction

    // Entries never written read as zero
    assign cmp_val = r_cmp_live ? r_q : '0;
    assign match   = r_cmp_en && (cmp_val == r_key);
    assign issue   = r_busy && (r_iss != CW'(DEPTH));
    assign last    = r_busy && !issue && r_cmp_en;

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_q <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.commit) begin
            r_mem[r_ptr] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_key <= i_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr      <= PW'(DEPTH - 2);
            r_fill     <= '0;
            r_iss      <= '0;
            r_addr     <= '0;
            r_busy     <= 1'b0;
            r_cmp_en   <= 1'b0;
            r_cmp_live <= 1'b0;
            r_dup      <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_done <= last;
            if (i_ctl.start) begin
                // scan oldest-first from the pointer; the last r_fill slots are written
                r_busy   <= 1'b1;
                r_iss    <= '0;
                r_addr   <= r_ptr;
                r_dup    <= 1'b0;
                r_cmp_en <= 1'b0;
            end else if (r_busy) begin
                r_cmp_en <= issue;
                if (issue) begin
                    r_cmp_live <= (r_iss >= (CW'(DEPTH) - r_fill));
                    r_addr     <= wrap_inc(r_addr);
                    r_iss      <= r_iss + 1'b1;
                end
                if (match) begin
                    r_dup <= 1'b1;
                end
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
            if (i_ctl.commit) begin
                r_ptr <= wrap_inc(r_ptr);
                if (r_fill != CW'(DEPTH)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

    assign o_sts.done = r_done;
    assign o_sts.dup  = r_dup;
    assign o_ptr      = r_ptr;

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= PW'(DEPTH - 1))
        else $error("window pointer out of range");

    a_commit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.commit |-> !r_busy)
        else $error("commit during scan");

    a_commit_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.commit |=> r_ptr != $past(r_ptr))
        else $error("pointer did not advance on commit");

endmodule

// ===== src/sequence_duplicate_filter_unit.sv =====
// Channel  | Valid        | Ready        | Payload          | Beat
// ---------+--------------+--------------+------------------+---------------------
// input    | i_in_valid   | o_in_ready   | i_in  (t_in)     | one packet header
// output   | o_out_valid  | i_out_ready  | o_out (t_out)    | one verdict
// config   | i_cfg_we     | -            | i_cfg_data       | reference sequence
//
// Per header, accept to accept: one comparator reads the window one entry per cycle,
// then the last compare, the done flag, the verdict register and taking the next
// header follow in that order.
// Reset is synchronous; a fill count marks unwritten slots as zero.
// A finished result waits in the output register; the next header is taken
// meanwhile and its scan runs, stalling only at the end until the output frees.
module sequence_duplicate_filter_unit #(
    parameter int WINDOW_DEPTH  = sdf_pkg::WINDOW_DEPTH_DEF,
    parameter int ADAPTER_COUNT = sdf_pkg::ADAPTER_COUNT_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  sdf_pkg::t_in              i_in,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output sdf_pkg::t_out             o_out,
    input  logic                      i_cfg_we,
    input  logic [sdf_pkg::SEQ_W-1:0] i_cfg_data
);

    localparam int PW = $clog2(WINDOW_DEPTH);
    localparam int AW = (ADAPTER_COUNT > 1) ? $clog2(ADAPTER_COUNT) : 1;

    sdf_pkg::t_state                   r_state, n_state;
    logic [sdf_pkg::SEQ_W-1:0]         r_ref;
    logic [sdf_pkg::SEQ_W-1:0]         r_seq;
    logic [sdf_pkg::LEN_W-1:0]         r_len;
    logic [sdf_pkg::PKT_W-1:0]         r_pkts;
    logic [sdf_pkg::PKT_W-1:0]         r_cnt [ADAPTER_COUNT];
    logic signed [sdf_pkg::SIG_W-1:0]  r_sig [ADAPTER_COUNT];
    logic                              r_out_valid, n_out_valid;
    sdf_pkg::t_out                     r_out, n_out;

    sdf_pkg::t_win_ctl                 win_ctl;
    sdf_pkg::t_win_sts                 win_sts;
    logic [PW-1:0]                     win_ptr;

    logic                              in_acc;
    logic                              ad_ok;
    logic [AW-1:0]                     ad_idx;
    logic [sdf_pkg::SEQ_W-1:0]         seq_dist;
    logic                              too_old;
    logic                              out_free;

    assign in_acc   = i_in_valid && o_in_ready;
    assign ad_ok    = 32'(i_in.adapter) < 32'(ADAPTER_COUNT);
    assign ad_idx   = AW'(i_in.adapter);
    assign seq_dist = r_seq - r_ref;
    assign too_old  = seq_dist[sdf_pkg::SEQ_W-1];
    assign out_free = !r_out_valid || i_out_ready;

    sdf_window #(
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (win_ctl),
        .i_key   (i_in.sequence_req),
        .o_sts   (win_sts),
        .o_ptr   (win_ptr)
    );

    always_comb begin
        n_state        = r_state;
        n_out_valid    = r_out_valid && !i_out_ready;
        n_out          = r_out;
        o_in_ready     = 1'b0;
        win_ctl.start  = 1'b0;
        win_ctl.commit = 1'b0;
        case (r_state)
            sdf_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                win_ctl.start = i_in_valid;
                if (i_in_valid) begin
                    n_state = sdf_pkg::S_SCAN;
                end
            end
            sdf_pkg::S_SCAN: begin
                if (win_sts.done) begin
                    n_state = sdf_pkg::S_DONE;
                end
            end
            sdf_pkg::S_DONE: begin
                // hold until the output register frees
                if (out_free) begin
                    n_out_valid                = 1'b1;
                    n_out.slot                 = sdf_pkg::SLOT_W'(win_ptr);
                    n_out.adapter_packets      = r_pkts;
                    n_out.forward_length       = '0;
                    if (win_sts.dup) begin
                        n_out.verdict = sdf_pkg::V_DUP;
                    end else if (too_old) begin
                        n_out.verdict = sdf_pkg::V_OLD;
                    end else begin
                        n_out.verdict        = sdf_pkg::V_ACCEPT;
                        n_out.forward_length = r_len;
                        win_ctl.commit       = 1'b1;
                    end
                    n_state = sdf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sdf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sdf_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (in_acc) begin
            r_seq <= i_in.sequence_req;
            r_len <= i_in.payload_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref  <= '0;
            r_pkts <= '0;
            for (int k = 0; k < ADAPTER_COUNT; k++) begin
                r_cnt[k] <= '0;
                r_sig[k] <= sdf_pkg::SIGNAL_RESET;
            end
        end else begin
            if (i_cfg_we) begin
                r_ref <= i_cfg_data;
            end
            if (in_acc) begin
                if (ad_ok) begin
                    r_cnt[ad_idx] <= r_cnt[ad_idx] + 1'b1;
                    r_sig[ad_idx] <= i_in.signal_dbm;
                    r_pkts        <= r_cnt[ad_idx] + 1'b1;
                end else begin
                    r_pkts <= '0;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        win_sts.done |-> r_state == sdf_pkg::S_SCAN)
        else $error("scan finished outside of scan state");

    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("took a header while one was in flight");

    a_drop_no_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.verdict != sdf_pkg::V_ACCEPT) |-> o_out.forward_length == '0)
        else $error("dropped packet carries a length");

    a_commit_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        win_ctl.commit |=> (o_out_valid && o_out.verdict == sdf_pkg::V_ACCEPT))
        else $error("window written without an accept verdict");

endmodule

// ===== test/sequence_duplicate_filter_unit_tb.sv =====
`timescale 1ns / 100ps

module sequence_duplicate_filter_unit_tb;

    localparam int WINDOW_DEPTH  = sdf_pkg::WINDOW_DEPTH_DEF;
    localparam int ADAPTER_COUNT = sdf_pkg::ADAPTER_COUNT_DEF;
    localparam logic [sdf_pkg::SEQ_W-1:0] HALF_RANGE = 32'h7FFF_FFFF;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 250;
    localparam int HOLD_CYCLES   = 600;
    localparam int TAIL_CYCLES   = 2 * WINDOW_DEPTH + 20;
    localparam int HISTORY_DEPTH = 120;

    class replay_filter_scoreboard;
        logic [sdf_pkg::SEQ_W-1:0]        seen_seq [WINDOW_DEPTH];
        int unsigned                      wr_ptr;
        logic [sdf_pkg::PKT_W-1:0]        packet_count [ADAPTER_COUNT];
        logic signed [sdf_pkg::SIG_W-1:0] last_signal [ADAPTER_COUNT];
        logic [sdf_pkg::SEQ_W-1:0]        reference_seq;
        sdf_pkg::t_out                    pending_verdicts [$];
        int unsigned                      mismatches;

        function new();
            foreach (seen_seq[i]) seen_seq[i] = '0;
            foreach (packet_count[i]) begin
                packet_count[i] = '0;
                last_signal[i]  = sdf_pkg::SIGNAL_RESET;
            end
            wr_ptr        = WINDOW_DEPTH - 2;
            reference_seq = '0;
            mismatches    = 0;
        endfunction

        // Work out the verdict for an accepted header and queue it.
        function void note_header(sdf_pkg::t_in hdr);
            sdf_pkg::t_out             verdict_out;
            logic                      is_dup;
            logic [sdf_pkg::SEQ_W-1:0] distance;
            verdict_out = '0;
            verdict_out.verdict = sdf_pkg::V_ACCEPT;
            verdict_out.slot = sdf_pkg::SLOT_W'(wr_ptr);
            if (int'(hdr.adapter) < ADAPTER_COUNT) begin
                last_signal[hdr.adapter]  = hdr.signal_dbm;
                packet_count[hdr.adapter] = packet_count[hdr.adapter] + 1'b1;
                verdict_out.adapter_packets = packet_count[hdr.adapter];
            end
            is_dup = 1'b0;
            foreach (seen_seq[i]) if (seen_seq[i] == hdr.sequence_req) is_dup = 1'b1;
            distance = hdr.sequence_req - reference_seq;
            if (is_dup) begin
                verdict_out.verdict = sdf_pkg::V_DUP;
            end else if (distance > HALF_RANGE) begin
                verdict_out.verdict = sdf_pkg::V_OLD;
            end else begin
                if (wr_ptr >= WINDOW_DEPTH) wr_ptr = 0;
                verdict_out.slot = sdf_pkg::SLOT_W'(wr_ptr);
                seen_seq[wr_ptr] = hdr.sequence_req;
                verdict_out.forward_length = hdr.payload_length;
                wr_ptr = wr_ptr + 1;
                if (wr_ptr >= WINDOW_DEPTH) wr_ptr = 0;
            end
            pending_verdicts.push_back(verdict_out);
        endfunction

        function void flag(string what, sdf_pkg::t_out want, sdf_pkg::t_out got);
            mismatches++;
            if (mismatches <= 10)
                $display({"%s: expected verdict=%0d slot=%0d len=%0d pkts=%0d, ",
                          "got verdict=%0d slot=%0d len=%0d pkts=%0d"},
                         what, want.verdict, want.slot, want.forward_length,
                         want.adapter_packets, got.verdict, got.slot,
                         got.forward_length, got.adapter_packets);
        endfunction

        function void check_verdict(sdf_pkg::t_out got);
            sdf_pkg::t_out want;
            if (pending_verdicts.size() == 0) begin
                flag("verdict with none pending", '0, got);
                return;
            end
            want = pending_verdicts.pop_front();
            if (got.verdict !== want.verdict || got.slot !== want.slot ||
                got.forward_length !== want.forward_length ||
                got.adapter_packets !== want.adapter_packets)
                flag("verdict mismatch", want, got);
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    sdf_pkg::t_in              i_in;
    logic                      o_out_valid;
    logic                      i_out_ready;
    sdf_pkg::t_out             o_out;
    logic                      i_cfg_we;
    logic [sdf_pkg::SEQ_W-1:0] i_cfg_data;

    replay_filter_scoreboard sb = new();
    bit          calm_stretch;
    int unsigned hold_requests;
    int unsigned holds_served;
    int unsigned hold_left;

    sequence_duplicate_filter_unit #(
        .WINDOW_DEPTH  (WINDOW_DEPTH),
        .ADAPTER_COUNT (ADAPTER_COUNT)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Result side: check each beat, then pick ready for the next edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_verdict(o_out);
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
            i_out_ready  <= 1'b0;
        end else begin
            i_out_ready <= calm_stretch || ($urandom_range(0, 99) >= 35);
        end
    end

    function automatic sdf_pkg::t_in pack_header(input logic [sdf_pkg::SEQ_W-1:0] seq,
                                                 input logic [sdf_pkg::ADAPT_W-1:0] ad,
                                                 input logic [sdf_pkg::SIG_W-1:0] sig,
                                                 input logic [sdf_pkg::LEN_W-1:0] len);
        sdf_pkg::t_in hdr;
        hdr.sequence_req   = seq;
        hdr.adapter        = ad;
        hdr.signal_dbm     = sig;
        hdr.payload_length = len;
        return hdr;
    endfunction

    task automatic send_header(input sdf_pkg::t_in hdr);
        while (!calm_stretch && $urandom_range(0, 99) < 35) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in       <= hdr;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_header(hdr);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending_verdicts.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reference(input logic [sdf_pkg::SEQ_W-1:0] value);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.reference_seq = value;
    endtask

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        sdf_pkg::t_in              hdr;
        logic [sdf_pkg::SEQ_W-1:0] phase_ref;
        logic [sdf_pkg::SEQ_W-1:0] cursor;
        logic [sdf_pkg::SEQ_W-1:0] recent [$];
        int                        pick;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in          = '0;
        i_out_ready   = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        calm_stretch  = 1'b0;
        hold_requests = 0;
        holds_served  = 0;
        hold_left     = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: cleared window, serial boundaries, wrap, field extremes.
        write_reference(32'h0000_0000);
        send_header(pack_header(32'h0000_0000, 3'd0, 8'h80, 9'd0));
        send_header(pack_header(32'h0000_0001, 3'd1, 8'h7F, 9'd400));
        send_header(pack_header(32'h0000_0001, 3'd2, 8'h00, 9'd17));
        send_header(pack_header(32'h7FFF_FFFF, 3'd3, 8'hFF, 9'd511));
        send_header(pack_header(32'h8000_0000, 3'd4, 8'h01, 9'd5));
        send_header(pack_header(32'hFFFF_FFFF, 3'd5, 8'h82, 9'd401));
        send_header(pack_header(32'h0000_0002, 3'd6, 8'hAA, 9'd256));
        send_header(pack_header(32'h0000_0003, 3'd7, 8'h55, 9'h1FF));
        send_header(pack_header(32'h5555_5555, 3'd7, 8'h55, 9'h155));
        send_header(pack_header(32'hAAAA_AAAA, 3'd0, 8'hAA, 9'h0AA));
        // A stored number now far behind the reference still reads as a duplicate.
        write_reference(32'hFFFF_FFFF);
        send_header(pack_header(32'h7FFF_FFFF, 3'd1, 8'h80, 9'd1));
        send_header(pack_header(32'hFFFF_FFFF, 3'd2, 8'h7F, 9'd2));
        send_header(pack_header(32'h7FFF_FFFE, 3'd3, 8'h00, 9'd400));
        send_header(pack_header(32'h7FFF_FFFE, 3'd4, 8'hC0, 9'd3));
        send_header(pack_header(32'h0000_0000, 3'd5, 8'h3F, 9'd4));
        send_header(pack_header(32'h8000_0000, 3'd6, 8'h80, 9'd400));

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       phase_ref = $urandom();
                1:       phase_ref = 32'h0000_0000;
                2:       phase_ref = 32'h8000_0000;
                3:       phase_ref = 32'hFFFF_FFFF;
                default: phase_ref = $urandom();
            endcase
            write_reference(phase_ref);
            cursor = phase_ref;
            calm_stretch = (phase == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 1 && n == 100) hold_requests++;
                if (phase == 2 && n == 125) wait_drained();
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    cursor = cursor + $urandom_range(1, 3);
                    hdr.sequence_req = cursor;
                end else if (pick < 75 && recent.size() != 0) begin
                    hdr.sequence_req = recent[$urandom_range(0, recent.size() - 1)];
                end else if (pick < 87) begin
                    hdr.sequence_req = phase_ref + 32'h8000_0000 +
                                       $urandom_range(0, 32'h7FFF_FFFF);
                end else if (pick < 93) begin
                    case ($urandom_range(0, 3))
                        0:       hdr.sequence_req = phase_ref;
                        1:       hdr.sequence_req = phase_ref + HALF_RANGE;
                        2:       hdr.sequence_req = phase_ref + HALF_RANGE + 1'b1;
                        default: hdr.sequence_req = phase_ref - 1'b1;
                    endcase
                end else begin
                    hdr.sequence_req = $urandom();
                end
                hdr.adapter    = sdf_pkg::ADAPT_W'($urandom_range(0, ADAPTER_COUNT - 1));
                hdr.signal_dbm = sdf_pkg::SIG_W'($urandom());
                hdr.payload_length = ($urandom_range(0, 9) == 0) ?
                                     sdf_pkg::LEN_W'($urandom_range(401, 511)) :
                                     sdf_pkg::LEN_W'($urandom_range(0, 400));
                recent.push_back(hdr.sequence_req);
                if (recent.size() > HISTORY_DEPTH) void'(recent.pop_front());
                send_header(hdr);
            end
        end
        calm_stretch = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_verdicts.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
src/sdf_pkg.sv
src/sdf_window.sv
src/sequence_duplicate_filter_unit.sv
test/sequence_duplicate_filter_unit_tb.sv
